// ===== sv/lprd_pkg.sv =====
// lprd_pkg: shared types and constants for the length-prefixed row deframer
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package lprd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned HDR_W    = 64;
    localparam int unsigned HCNT_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned M_TDATA_W = 144;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [HDR_W-1:0] HDR_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HDR_LOG2  = 2'd0,
        REG_MSB_FIRST = 2'd1,
        REG_ITEM_SIZE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        hdr_log2;
        logic              msb_first;
        logic [BYTE_W-1:0] item_size;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_role;
        logic [CNT_W-1:0]  row_index;
        logic              row_done;
        logic [CNT_W-1:0]  row_end_items;
        logic              stream_done;
        logic              status;
        logic [CNT_W-1:0]  rows_total;
        logic [CNT_W-1:0]  bytes_consumed;
    } result_t;

endpackage

// ===== sv/lprd_in_reg.sv =====
// lprd_in_reg: input register stage of the deframer
// depends on lprd_pkg
`timescale 1ns / 1ps

module lprd_in_reg
    import lprd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     out_valid,
    input  logic     out_take,
    output in_item_t out_item
);

    logic     valid_reg;
    in_item_t item_reg;

    // take a new transaction when empty or when the held one leaves this cycle
    assign in_ready  = !valid_reg || out_take;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/lprd_core.sv =====
// lprd_core: parser state and per-byte step logic of the deframer
// depends on lprd_pkg
`timescale 1ns / 1ps

module lprd_core
    import lprd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     step_en,
    input  in_item_t item,
    output result_t  result
);

    logic [HDR_W-1:0]  header_value_reg, header_value_next;
    logic [HCNT_W-1:0] header_count_reg, header_count_next;
    logic              in_payload_reg, in_payload_next;
    logic [HDR_W-1:0]  payload_left_reg, payload_left_next;
    logic [CNT_W-1:0]  row_counter_reg, row_counter_next;
    logic [CNT_W-1:0]  item_total_reg, item_total_next;
    logic [CNT_W-1:0]  consumed_count_reg, consumed_count_next;
    logic [CNT_W-1:0]  byte_counter_reg, byte_counter_next;

    logic [CNT_W-1:0]         byte_cnt_inc;
    logic [HCNT_W:0]          hcount_inc;
    logic [HCNT_W:0]          hlen;
    logic                     hdr_full;
    logic [HDR_W-1:0]         hdr_le;
    logic [HDR_W-1:0]         hdr_asm;
    logic [HDR_W+BYTE_W-1:0]  prod;
    logic [HDR_W-1:0]         pay_bytes;
    logic [HDR_W-1:0]         pl_dec;
    logic                     finish;
    logic [HDR_W-1:0]         hv_cur;
    logic [CNT_W:0]           item_sum;
    logic [CNT_W-1:0]         item_sat;
    logic [CNT_W-1:0]         row_inc;

    always_comb begin
        byte_cnt_inc = (byte_counter_reg == CNT_MAX) ? CNT_MAX : byte_counter_reg + 1'b1;
        hcount_inc   = {1'b0, header_count_reg} + 1'b1;
        hlen         = (HCNT_W+1)'(1) << cfg.hdr_log2;
        hdr_full     = (hcount_inc >= hlen);

        // little endian drops the byte at its lane, big endian shifts it in
        hdr_le  = header_value_reg
                  | ({{(HDR_W-BYTE_W){1'b0}}, item.data_byte} << {header_count_reg, 3'b000});
        hdr_asm = cfg.msb_first ? {header_value_reg[HDR_W-BYTE_W-1:0], item.data_byte}
                                : hdr_le;

        // payload byte count, saturating on overflow
        prod      = hdr_asm * cfg.item_size;
        pay_bytes = (|prod[HDR_W+BYTE_W-1:HDR_W]) ? HDR_MAX : prod[HDR_W-1:0];

        // a saturated payload never counts down
        pl_dec = (payload_left_reg == HDR_MAX) ? HDR_MAX : payload_left_reg - 1'b1;

        finish = in_payload_reg ? (pl_dec == '0) : (hdr_full && (pay_bytes == '0));
        hv_cur = in_payload_reg ? header_value_reg : hdr_asm;

        item_sum = {1'b0, item_total_reg} + {1'b0, hv_cur[CNT_W-1:0]};
        item_sat = ((|hv_cur[HDR_W-1:CNT_W]) || item_sum[CNT_W]) ? CNT_MAX
                                                                 : item_sum[CNT_W-1:0];
        row_inc  = (row_counter_reg == CNT_MAX) ? CNT_MAX : row_counter_reg + 1'b1;
    end

    always_comb begin
        byte_counter_next   = byte_cnt_inc;
        row_counter_next    = row_counter_reg;
        item_total_next     = item_total_reg;
        consumed_count_next = consumed_count_reg;
        header_value_next   = header_value_reg;
        header_count_next   = header_count_reg;
        in_payload_next     = in_payload_reg;
        payload_left_next   = payload_left_reg;

        if (finish) begin
            row_counter_next    = row_inc;
            item_total_next     = item_sat;
            consumed_count_next = byte_cnt_inc;
            header_value_next   = '0;
            header_count_next   = '0;
            in_payload_next     = 1'b0;
            payload_left_next   = '0;
        end else if (in_payload_reg) begin
            payload_left_next = pl_dec;
        end else begin
            header_value_next = hdr_asm;
            if (hdr_full) begin
                header_count_next = '0;
                in_payload_next   = 1'b1;
                payload_left_next = pay_bytes;
            end else begin
                header_count_next = hcount_inc[HCNT_W-1:0];
            end
        end
    end

    always_comb begin
        result.payload_byte   = item.data_byte;
        result.byte_role      = in_payload_reg;
        result.row_index      = row_counter_reg;
        result.row_done       = finish;
        result.row_end_items  = finish ? item_sat : '0;
        result.stream_done    = item.last_byte;
        // any byte that does not close a row leaves a header or payload open
        result.status         = item.last_byte && !finish;
        result.rows_total     = row_counter_next;
        result.bytes_consumed = consumed_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_value_reg   <= '0;
            header_count_reg   <= '0;
            in_payload_reg     <= 1'b0;
            payload_left_reg   <= '0;
            row_counter_reg    <= '0;
            item_total_reg     <= '0;
            consumed_count_reg <= '0;
            byte_counter_reg   <= '0;
        end else if (step_en) begin
            if (item.last_byte) begin
                header_value_reg   <= '0;
                header_count_reg   <= '0;
                in_payload_reg     <= 1'b0;
                payload_left_reg   <= '0;
                row_counter_reg    <= '0;
                item_total_reg     <= '0;
                consumed_count_reg <= '0;
                byte_counter_reg   <= '0;
            end else begin
                header_value_reg   <= header_value_next;
                header_count_reg   <= header_count_next;
                in_payload_reg     <= in_payload_next;
                payload_left_reg   <= payload_left_next;
                row_counter_reg    <= row_counter_next;
                item_total_reg     <= item_total_next;
                consumed_count_reg <= consumed_count_next;
                byte_counter_reg   <= byte_counter_next;
            end
        end
    end

endmodule

// ===== sv/length_prefixed_row_deframer_unit.sv =====
// length_prefixed_row_deframer_unit: top level of the row deframer
// depends on lprd_pkg, lprd_in_reg and lprd_core
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: data_byte, s_tlast: last_byte
//  m_       | out | m_tvalid/m_tready  | m_tdata: result fields, m_tuser: role,
//           |     |                    | m_tlast: stream_done
//  cfg_     | in  | cfg_wr_en          | cfg_addr, cfg_wr_data
//
// one transaction in, one result out; a byte is taken every cycle when the
// result side keeps up, and its result reaches m_ through the input register,
// then step logic into the result register
// the header multiply by item_size and the 64-bit payload countdown sit in the
// combinational step logic between the two registers
// reset (synchronous, aresetn low) empties both registers and clears the parser
// state; configuration returns to hdr_log2 0, little endian, item_size 1
// a stalled result holds; the input register keeps accepting until it is full
`timescale 1ns / 1ps

module length_prefixed_row_deframer_unit
    import lprd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] payload_byte, [39:8] row_index, [40] row_done, [72:41] row_end_items,
    // [73] status, [105:74] rows_total, [137:106] bytes_consumed, rest zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tuser,   // byte_role
    output logic                   m_tlast,   // stream_done

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    cfg_t     cfg_reg;
    in_item_t s_item;
    in_item_t stage_item;
    logic     stage_valid;
    logic     advance;
    result_t  step_result;
    logic     m_valid_reg;
    result_t  result_reg;

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hdr_log2  <= 2'd0;
            cfg_reg.msb_first <= 1'b0;
            cfg_reg.item_size <= BYTE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                REG_HDR_LOG2:  cfg_reg.hdr_log2  <= cfg_wr_data[1:0];
                REG_MSB_FIRST: cfg_reg.msb_first <= cfg_wr_data[0];
                REG_ITEM_SIZE: cfg_reg.item_size <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    // the staged byte steps the parser when the result register is free
    assign advance = stage_valid && (!m_valid_reg || m_tready);

    lprd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (stage_valid),
        .out_take  (advance),
        .out_item  (stage_item)
    );

    lprd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step_en (advance),
        .item    (stage_item),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.byte_role;
    assign m_tlast  = result_reg.stream_done;
    assign m_tdata  = {6'b0,
                       result_reg.bytes_consumed,
                       result_reg.rows_total,
                       result_reg.status,
                       result_reg.row_end_items,
                       result_reg.row_done,
                       result_reg.row_index,
                       result_reg.payload_byte};

endmodule
